// ===== rtl/iom_pkg.sv =====
`default_nettype none

package iom_pkg;

    // Default sizes of the interval lists and of the stored coordinates.
    localparam int MAX_INTERVALS_DEF = 32;
    localparam int COORD_BITS_DEF    = 32;

    // Widths of the stream payload and of the fixed fields.
    localparam int FIELD_W     = 32;
    localparam int IN_DATA_W   = 64;
    localparam int REQ_W       = 2;
    localparam int IDX_OUT_W   = 5;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 1;

    // Configuration port.
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_MIN_OVERLAP = 0;

    // Request kinds carried in s_tuser.
    localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

    // List selector carried in m_tuser.
    localparam logic LIST_A = 1'b0;
    localparam logic LIST_B = 1'b1;

endpackage : iom_pkg

`default_nettype wire

// ===== rtl/interval_overlap_marker.sv =====
`default_nettype none

// Interval overlap marker.
// The slave stream takes requests: s_tuser selects load into list A, load into
// list B or run; s_tdata carries the start (low word) and the inclusive end.
// A load produces nothing; a load into a full list is dropped.
// A run compares every A interval with every B interval on one shared comparator,
// one pair per cycle, then waits for the memory read, the two comparator stages and
// the last marking to drain. It then emits one result per A entry, then per B entry,
// one per cycle while m_tready is high, with m_tlast on the final one, and both lists
// are emptied. A run with one list empty skips the comparison; a run with both empty
// emits nothing. s_tready is low from the start of a run until its last result has
// entered the output register.
// A stalled receiver holds the output register, and the emission waits with it.
// Reset empties both lists, clears all marks and sets min_overlap to 1.
// The APB port holds min_overlap at address 0; a value of 0 acts as 1.
module interval_overlap_marker #(
    parameter int MAX_INTERVALS = iom_pkg::MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = iom_pkg::COORD_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [iom_pkg::IN_DATA_W-1:0]   s_tdata,  // interval_start, interval_end
    input  wire logic [iom_pkg::REQ_W-1:0]       s_tuser,  // req_type
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [iom_pkg::OUT_DATA_W-1:0]       m_tdata,  // entry_index, overlapped, zero pad
    output logic [iom_pkg::OUT_USER_W-1:0]       m_tuser,  // list_id
    output logic                                 m_tlast,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [iom_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [iom_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [iom_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import iom_pkg::*;

    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int TOT_W = $clog2(2 * MAX_INTERVALS + 1);
    localparam int TAG_W = 2 * IDX_W;
    localparam int ENT_W = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIR,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_a_reg;
    logic [CNT_W-1:0]        count_b_reg;
    logic [MAX_INTERVALS-1:0] marks_a_reg;
    logic [MAX_INTERVALS-1:0] marks_b_reg;
    logic [IDX_W-1:0]        ai_reg;
    logic [IDX_W-1:0]        bj_reg;
    logic                    rd_vld_reg;
    logic [TAG_W-1:0]        rd_tag_reg;
    logic [TOT_W-1:0]        k_reg;
    logic [CFG_DATA_W-1:0]   min_overlap_reg;
    logic [CFG_DATA_W-1:0]   thr_reg;

    logic                    m_tvalid_reg;
    logic                    m_list_reg;
    logic [IDX_OUT_W-1:0]    m_idx_reg;
    logic                    m_mark_reg;
    logic                    m_last_reg;

    logic [ENT_W-1:0]        mem_a [MAX_INTERVALS];
    logic [ENT_W-1:0]        mem_b [MAX_INTERVALS];
    logic [ENT_W-1:0]        rd_a_reg;
    logic [ENT_W-1:0]        rd_b_reg;

    logic                    s_accept;
    logic                    load_a_en;
    logic                    load_b_en;
    logic [ENT_W-1:0]        load_word;
    logic                    cfg_write;
    logic                    cmp_busy;
    logic                    hit_valid;
    logic                    hit;
    logic [TAG_W-1:0]        hit_tag;
    logic [IDX_W-1:0]        hit_i;
    logic [IDX_W-1:0]        hit_j;
    logic                    last_a;
    logic                    last_b;
    logic [TOT_W-1:0]        total;
    logic                    emit_in_a;
    logic [TOT_W-1:0]        idx_b_wide;
    logic [IDX_W-1:0]        emit_idx;
    logic                    emit_mark;
    logic                    out_free;

    // Request decode.
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign load_a_en = s_accept && (s_tuser == REQ_LOAD_A)
                       && (count_a_reg < CNT_W'(MAX_INTERVALS));
    assign load_b_en = s_accept && (s_tuser == REQ_LOAD_B)
                       && (count_b_reg < CNT_W'(MAX_INTERVALS));
    assign load_word = {COORD_BITS'(s_tdata[2*FIELD_W-1:FIELD_W]),
                        COORD_BITS'(s_tdata[FIELD_W-1:0])};

    // Configuration register; the threshold is the minimum length less one.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_MIN_OVERLAP))
                       ? min_overlap_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_overlap_reg <= CFG_DATA_W'(1);
            thr_reg         <= '0;
        end else if (cfg_write
                     && (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_MIN_OVERLAP))) begin
            min_overlap_reg <= pwdata;
            thr_reg         <= (pwdata == '0) ? '0 : pwdata - CFG_DATA_W'(1);
        end
    end

    // Interval memories: written on load, read at the sequencer's pair address.
    always_ff @(posedge aclk) begin
        if (load_a_en) begin
            mem_a[count_a_reg[IDX_W-1:0]] <= load_word;
        end
        if (load_b_en) begin
            mem_b[count_b_reg[IDX_W-1:0]] <= load_word;
        end
        rd_a_reg <= mem_a[ai_reg];
        rd_b_reg <= mem_b[bj_reg];
    end

    // Shared pair comparator.
    iom_pair_cmp #(
        .COORD_BITS (COORD_BITS),
        .TAG_W      (TAG_W)
    ) u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_vld_reg),
        .sa        (rd_a_reg[COORD_BITS-1:0]),
        .ea        (rd_a_reg[ENT_W-1:COORD_BITS]),
        .sb        (rd_b_reg[COORD_BITS-1:0]),
        .eb        (rd_b_reg[ENT_W-1:COORD_BITS]),
        .thr       (thr_reg),
        .in_tag    (rd_tag_reg),
        .busy      (cmp_busy),
        .hit_valid (hit_valid),
        .hit       (hit),
        .hit_tag   (hit_tag)
    );

    assign hit_i = hit_tag[TAG_W-1:IDX_W];
    assign hit_j = hit_tag[IDX_W-1:0];

    // Pair walk and emission bookkeeping.
    assign last_a     = (CNT_W'(ai_reg) == count_a_reg - CNT_W'(1));
    assign last_b     = (CNT_W'(bj_reg) == count_b_reg - CNT_W'(1));
    assign total      = TOT_W'(count_a_reg) + TOT_W'(count_b_reg);
    assign emit_in_a  = (k_reg < TOT_W'(count_a_reg));
    assign idx_b_wide = k_reg - TOT_W'(count_a_reg);
    assign emit_idx   = emit_in_a ? k_reg[IDX_W-1:0] : idx_b_wide[IDX_W-1:0];
    assign emit_mark  = emit_in_a ? marks_a_reg[emit_idx] : marks_b_reg[emit_idx];
    assign out_free   = !m_tvalid_reg || m_tready;

    // Sequencer with list counts, marks and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            marks_a_reg  <= '0;
            marks_b_reg  <= '0;
            ai_reg       <= '0;
            bj_reg       <= '0;
            rd_vld_reg   <= 1'b0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A memory read is issued on every cycle of the pair walk.
            rd_vld_reg <= (state_reg == ST_PAIR);
            // The output register fills while emitting and empties when taken.
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // A counting pair marks both of its intervals.
            if (hit_valid && hit) begin
                marks_a_reg[hit_i] <= 1'b1;
                marks_b_reg[hit_j] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (load_a_en) begin
                        marks_a_reg[count_a_reg[IDX_W-1:0]] <= 1'b0;
                        count_a_reg <= count_a_reg + CNT_W'(1);
                    end
                    if (load_b_en) begin
                        marks_b_reg[count_b_reg[IDX_W-1:0]] <= 1'b0;
                        count_b_reg <= count_b_reg + CNT_W'(1);
                    end
                    if (s_accept && (s_tuser == REQ_RUN)) begin
                        ai_reg <= '0;
                        bj_reg <= '0;
                        k_reg  <= '0;
                        if ((count_a_reg != '0) && (count_b_reg != '0)) begin
                            state_reg <= ST_PAIR;
                        end else if (total != '0) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_PAIR: begin
                    rd_tag_reg <= {ai_reg, bj_reg};
                    if (last_b) begin
                        bj_reg <= '0;
                        if (last_a) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            ai_reg <= ai_reg + IDX_W'(1);
                        end
                    end else begin
                        bj_reg <= bj_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // Wait until the last pair has left the comparator and marked.
                    if (!rd_vld_reg && !cmp_busy) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_list_reg   <= emit_in_a ? LIST_A : LIST_B;
                        m_idx_reg    <= IDX_OUT_W'(emit_idx);
                        m_mark_reg   <= emit_mark;
                        m_last_reg   <= (k_reg == total - TOT_W'(1));
                        k_reg        <= k_reg + TOT_W'(1);
                        if (k_reg == total - TOT_W'(1)) begin
                            count_a_reg <= '0;
                            count_b_reg <= '0;
                            marks_a_reg <= '0;
                            marks_b_reg <= '0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - IDX_OUT_W - 1)'(0), m_mark_reg, m_idx_reg};
    assign m_tuser  = m_list_reg;
    assign m_tlast  = m_last_reg;

    // Nothing is left in the comparison pipeline once the block is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !cmp_busy))
        else $error("comparison still in flight while idle");

    // The list counts never exceed the list capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a_reg <= CNT_W'(MAX_INTERVALS)) && (count_b_reg <= CNT_W'(MAX_INTERVALS)))
        else $error("list count beyond capacity");

    // A comparator result always refers to entries that are loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hit_valid |-> ((CNT_W'(hit_i) < count_a_reg) && (CNT_W'(hit_j) < count_b_reg)))
        else $error("comparator result for an unloaded entry");

    // Finishing the emission empties both lists and clears every mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free && (k_reg == total - TOT_W'(1)))
        |=> ((count_a_reg == '0) && (count_b_reg == '0)
             && (marks_a_reg == '0) && (marks_b_reg == '0) && m_tlast))
        else $error("lists not emptied at the end of a run");

endmodule : interval_overlap_marker

`default_nettype wire

// ===== rtl/iom_pair_cmp.sv =====
`default_nettype none

// Two-stage pair comparator: intersection bounds first, then the length test.
module iom_pair_cmp #(
    parameter int COORD_BITS = iom_pkg::COORD_BITS_DEF,
    parameter int TAG_W      = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [COORD_BITS-1:0]         sa,
    input  wire logic [COORD_BITS-1:0]         ea,
    input  wire logic [COORD_BITS-1:0]         sb,
    input  wire logic [COORD_BITS-1:0]         eb,
    input  wire logic [iom_pkg::CFG_DATA_W-1:0] thr,
    input  wire logic [TAG_W-1:0]              in_tag,
    output logic                               busy,
    output logic                               hit_valid,
    output logic                               hit,
    output logic [TAG_W-1:0]                   hit_tag
);
    import iom_pkg::*;

    localparam int CMP_W = (COORD_BITS > CFG_DATA_W) ? COORD_BITS : CFG_DATA_W;

    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] lo_reg;
    logic [COORD_BITS-1:0] hi_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic [COORD_BITS-1:0] diff;
    logic                  hit_next;
    logic                  hit_valid_reg;
    logic                  hit_reg;
    logic [TAG_W-1:0]      hit_tag_reg;

    // Stage one: the later start and the earlier end bound the shared part.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        lo_reg     <= (sa > sb) ? sa : sb;
        hi_reg     <= (ea < eb) ? ea : eb;
        s1_tag_reg <= in_tag;
    end

    // Stage two: the pair counts when the bounds meet and the span reaches the threshold.
    assign diff     = hi_reg - lo_reg;
    assign hit_next = (lo_reg <= hi_reg) && (CMP_W'(diff) >= CMP_W'(thr));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_valid_reg <= 1'b0;
        end else begin
            hit_valid_reg <= s1_valid_reg;
        end
        hit_reg     <= hit_next;
        hit_tag_reg <= s1_tag_reg;
    end

    assign busy      = s1_valid_reg | hit_valid_reg;
    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;
    assign hit_tag   = hit_tag_reg;

endmodule : iom_pair_cmp

`default_nettype wire

// ===== bench/tb_interval_overlap_marker.sv =====
`timescale 1ns / 100ps

module tb_interval_overlap_marker;

    import iom_pkg::*;

    // Request kind that the block ignores.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [31:0] COORD_MAX = 32'hFFFF_FFFF;
    localparam int LIST_DEPTH = MAX_INTERVALS_DEF;
    localparam int RANDOM_ITEMS = 380;

    // One expected mark as it leaves the result stream.
    typedef struct {
        logic       list_id;
        logic [4:0] entry_index;
        logic       overlapped;
        logic       last;
    } mark_t;

    // Mirror of the two interval lists; predicts the marks of every run and
    // compares them with the marks that the block emits.
    class mark_scoreboard;
        logic [31:0] starts [2][LIST_DEPTH];
        logic [31:0] ends [2][LIST_DEPTH];
        bit          marked [2][LIST_DEPTH];
        int          count [2];
        logic [31:0] min_overlap;
        mark_t       expected_marks [$];
        int          errors;

        function new();
            min_overlap = 32'd1;
            count[0] = 0;
            count[1] = 0;
            errors = 0;
        endfunction

        function void set_min_overlap(logic [31:0] value);
            min_overlap = value;
        endfunction

        function int pending();
            return expected_marks.size();
        endfunction

        // A pair counts when the intervals meet and share enough positions.
        function bit shares_enough(logic [31:0] sa, logic [31:0] ea,
                                   logic [31:0] sb, logic [31:0] eb);
            logic [31:0] lo;
            logic [31:0] hi;
            lo = (sa > sb) ? sa : sb;
            hi = (ea < eb) ? ea : eb;
            if (lo > hi)
                return 1'b0;
            if (min_overlap == 32'd0)
                return 1'b1;
            return (hi - lo) >= (min_overlap - 32'd1);
        endfunction

        // Note one accepted request transaction.
        function void note_request(logic [REQ_W-1:0] req, logic [31:0] s,
                                   logic [31:0] e);
            int lst;
            int total;
            int k;
            mark_t m;
            if (req == REQ_LOAD_A || req == REQ_LOAD_B) begin
                lst = (req == REQ_LOAD_A) ? 0 : 1;
                if (count[lst] < LIST_DEPTH) begin
                    starts[lst][count[lst]] = s;
                    ends[lst][count[lst]] = e;
                    marked[lst][count[lst]] = 1'b0;
                    count[lst]++;
                end
                return;
            end
            if (req != REQ_RUN)
                return;
            // Compare every A entry with every B entry.
            for (int i = 0; i < count[0]; i++) begin
                for (int j = 0; j < count[1]; j++) begin
                    if (shares_enough(starts[0][i], ends[0][i], starts[1][j], ends[1][j])) begin
                        marked[0][i] = 1'b1;
                        marked[1][j] = 1'b1;
                    end
                end
            end
            // One mark per A entry, then one per B entry.
            total = count[0] + count[1];
            k = 0;
            for (int lst_i = 0; lst_i < 2; lst_i++) begin
                for (int i = 0; i < count[lst_i]; i++) begin
                    m.list_id = (lst_i == 0) ? LIST_A : LIST_B;
                    m.entry_index = i[4:0];
                    m.overlapped = marked[lst_i][i];
                    k++;
                    m.last = (k == total);
                    expected_marks.push_back(m);
                    marked[lst_i][i] = 1'b0;
                end
            end
            count[0] = 0;
            count[1] = 0;
        endfunction

        // Check one accepted result transaction against the oldest expectation.
        function void check_mark(mark_t got);
            mark_t want;
            if (expected_marks.size() == 0) begin
                $error("unexpected result: list_id %0d entry_index %0d overlapped %0d last %0d",
                       got.list_id, got.entry_index, got.overlapped, got.last);
                errors++;
                return;
            end
            want = expected_marks.pop_front();
            if (got.list_id !== want.list_id) begin
                $error("list_id: expected %0d, actual %0d", want.list_id, got.list_id);
                errors++;
            end
            if (got.entry_index !== want.entry_index) begin
                $error("entry_index: expected %0d, actual %0d",
                       want.entry_index, got.entry_index);
                errors++;
            end
            if (got.overlapped !== want.overlapped) begin
                $error("overlapped: expected %0d, actual %0d", want.overlapped, got.overlapped);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // interval_start, interval_end
    logic [REQ_W-1:0]      s_tuser;   // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // entry_index, overlapped, zero pad
    logic [OUT_USER_W-1:0] m_tuser;   // list_id
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    mark_scoreboard marks = new();
    bit             no_idling;
    int             items_sent;

    interval_overlap_marker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock.
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Watchdog.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Monitor both streams at the rising edge.
    always @(posedge aclk) begin
        mark_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                marks.note_request(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready) begin
                got.list_id = m_tuser[0];
                got.entry_index = m_tdata[4:0];
                got.overlapped = m_tdata[5];
                got.last = m_tlast;
                marks.check_mark(got);
            end
        end
    end

    // Receiver: a random stall before each result transaction.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = no_idling ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Send one request after a random gap and wait for its transaction.
    task automatic send_item(logic [REQ_W-1:0] req, logic [31:0] s, logic [31:0] e);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {e, s};
        do @(posedge aclk); while (!s_tready);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    // Wait until every expected mark has arrived and the block has settled.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (marks.pending() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_min_overlap(logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CFG_ADDR_W'(REG_MIN_OVERLAP * 4);
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        marks.set_min_overlap(value);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Draw one interval around the batch base, with edge cases mixed in.
    task automatic pick_interval(logic [31:0] base, output logic [31:0] s,
                                 output logic [31:0] e);
        case ($urandom_range(0, 9))
            0: begin
                s = $urandom;
                e = $urandom;
            end
            1: begin
                s = base + $urandom_range(50, 200);
                e = s - $urandom_range(1, 50);
            end
            2: begin
                e = COORD_MAX;
                s = COORD_MAX - $urandom_range(0, 100);
            end
            3: begin
                s = 32'd0;
                e = $urandom_range(0, 100);
            end
            default: begin
                s = base + $urandom_range(0, 200);
                e = s + $urandom_range(0, 40);
            end
        endcase
    endtask

    function automatic int pick_list_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(30, 34);
        return $urandom_range(1, 6);
    endfunction

    // Load both lists in random order, with the odd ignored request, then run.
    task automatic run_batch(int na, int nb);
        logic [31:0] base;
        logic [31:0] s;
        logic [31:0] e;
        base = $urandom_range(0, 32'hFFFF_0000);
        while (na + nb > 0) begin
            if ($urandom_range(0, 11) == 0)
                send_item(REQ_UNUSED, $urandom, $urandom);
            pick_interval(base, s, e);
            if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
                send_item(REQ_LOAD_A, s, e);
                na--;
            end else begin
                send_item(REQ_LOAD_B, s, e);
                nb--;
            end
        end
        send_item(REQ_RUN, $urandom, $urandom);
    endtask

    // Stimulus.
    initial begin
        logic [31:0] value;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_LOAD_A;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idling = 1'b0;
        items_sent = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty run, ignored request, extremes and touching edges.
        send_item(REQ_RUN, 32'd0, 32'd0);
        send_item(REQ_UNUSED, $urandom, $urandom);
        send_item(REQ_LOAD_A, 32'd0, 32'd0);
        send_item(REQ_LOAD_B, 32'd0, 32'd0);
        send_item(REQ_LOAD_A, COORD_MAX, COORD_MAX);
        send_item(REQ_LOAD_B, 32'hFFFF_FFF0, COORD_MAX);
        send_item(REQ_LOAD_A, 32'd10, 32'd5);
        send_item(REQ_LOAD_A, 32'd5, 32'd10);
        send_item(REQ_LOAD_B, 32'd10, 32'd20);
        send_item(REQ_LOAD_A, 32'd100, 32'd200);
        send_item(REQ_LOAD_B, 32'd201, 32'd300);
        send_item(REQ_RUN, COORD_MAX, COORD_MAX);
        // Only one list filled.
        send_item(REQ_LOAD_A, 32'd1, 32'd2);
        send_item(REQ_RUN, 32'd0, 32'd0);
        send_item(REQ_LOAD_B, 32'd3, 32'd4);
        send_item(REQ_RUN, 32'd0, 32'd0);
        // A zero minimum behaves like one.
        wait_idle();
        write_min_overlap(32'd0);
        send_item(REQ_LOAD_A, 32'd7, 32'd7);
        send_item(REQ_LOAD_B, 32'd7, 32'd7);
        send_item(REQ_RUN, 32'd0, 32'd0);
        // Largest minimum: only the widest shared spans count.
        wait_idle();
        write_min_overlap(COORD_MAX);
        send_item(REQ_LOAD_A, 32'd0, COORD_MAX);
        send_item(REQ_LOAD_A, 32'd2, COORD_MAX);
        send_item(REQ_LOAD_B, 32'd0, COORD_MAX);
        send_item(REQ_RUN, 32'd0, 32'd0);
        wait_idle();
        write_min_overlap(32'd3);

        // Random batches, with the minimum changed between some of them.
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                case ($urandom_range(0, 4))
                    0: value = 32'd0;
                    1: value = 32'd1;
                    2: value = $urandom_range(2, 40);
                    3: value = COORD_MAX;
                    default: value = $urandom;
                endcase
                write_min_overlap(value);
            end
            no_idling = ($urandom_range(0, 4) == 0);
            run_batch(pick_list_size(), pick_list_size());
        end

        // Drain and report.
        no_idling = 1'b0;
        wait_idle();
        repeat (20) @(negedge aclk);
        if (marks.errors == 0 && marks.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
